[rtl/core/lccc_pkg.sv]
`default_nettype none

package lccc_pkg;

  localparam int RANGE_COUNT_DEF = 8;
  localparam int DIV_W           = 32;
  localparam int LOAD_W          = 17;
  localparam int CODE_W          = 12;
  localparam int NUM_W           = LOAD_W + CODE_W;

  // Configuration register indexes
  localparam logic [1:0] REG_ISET_EN  = 2'd0;
  localparam logic [1:0] REG_MAX_RES  = 2'd1;
  localparam logic [1:0] REG_EXT_RES  = 2'd2;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } lccc_div_stat_t;

  // Nominal full-scale current of each range, in microamps
  function automatic logic [15:0] nom_fs(input logic [2:0] idx);
    logic [15:0] v;
    case (idx)
      3'd0:    v = 16'd5000;
      3'd1:    v = 16'd10000;
      3'd2:    v = 16'd15000;
      3'd3:    v = 16'd20000;
      3'd4:    v = 16'd23000;
      3'd5:    v = 16'd25000;
      3'd6:    v = 16'd30000;
      default: v = 16'd50000;
    endcase
    return v;
  endfunction

  // 4095 * load, formed as (load << 12) - load
  function automatic logic [NUM_W-1:0] code_num(input logic [LOAD_W-1:0] load);
    return {load, {CODE_W{1'b0}}} - {{CODE_W{1'b0}}, load};
  endfunction

endpackage

`default_nettype wire

[rtl/core/led_current_code_calc.sv]
// Sequence: fixed-range mode runs one division; scaled mode searches the ranges, then divides
//   twice, or once with a zero external resistor, and reports an error with no division.
// Throughput: one transaction at a time; the bit-serial divider (run up to twice in scaled
//   mode) sets the rate. A new load may be accepted in the strobe cycle.
// Reset: synchronous, active high; configuration registers return to enable=1, 60000 / 60000 ohms.
// The result is shown for exactly one cycle under done; the receiver cannot stall.
`default_nettype none

module led_current_code_calc
  import lccc_pkg::*;
#(
  parameter int RANGE_COUNT = RANGE_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // command channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [LOAD_W-1:0] load_ua,
  // configuration write channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [19:0]       cfg_data,
  // result
  output logic                   done,
  output logic                   error,
  output logic [2:0]             range_index,
  output logic [CODE_W-1:0]      current_code,
  output logic [7:0]             low_byte,
  output logic [6:0]             high_byte
);

  localparam logic [2:0] LAST_IDX = 3'(RANGE_COUNT - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SRCH = 6'b000100,
    ST_CMP  = 6'b001000,
    ST_DIV1 = 6'b010000,
    ST_DIV2 = 6'b100000
  } seq_t;

  seq_t state;

  // configuration registers
  logic        iset_en;
  logic [15:0] max_res;
  logic [19:0] ext_res;

  // working registers
  logic [LOAD_W-1:0] load_r;
  logic [2:0]        idx;
  logic [37:0]       lhs;   // (load + 1) * ext_res
  logic [31:0]       prod;  // nominal * max_res
  logic              found;
  logic              accept;

  // divider hookup
  logic                 div_start;
  logic [DIV_W-1:0]     div_dvd;
  logic [DIV_W-1:0]     div_dvs;
  logic [DIV_W-1:0]     div_q;
  lccc_div_stat_t       div_stat;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;

  // load < floor(P / E) is the same as (load + 1) * E <= P; a zero E always passes
  assign found = (lhs <= {6'b0, prod});

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      iset_en <= 1'b1;
      max_res <= 16'd60000;
      ext_res <= 20'd60000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ISET_EN: iset_en <= cfg_data[0];
        REG_MAX_RES: max_res <= cfg_data[15:0];
        REG_EXT_RES: ext_res <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Divider launch: fixed-range code, scaled full-scale, or code after scaling
  // ---------------------------------------------------------------------------
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && !iset_en) begin
          div_start = 1'b1;
          div_dvd   = DIV_W'(code_num(load_ua));
          div_dvs   = DIV_W'(nom_fs(LAST_IDX));
        end
      end
      ST_CMP: begin
        if (found) begin
          div_start = 1'b1;
          if (ext_res == '0) begin
            // saturated full-scale
            div_dvd = DIV_W'(code_num(load_r));
            div_dvs = '1;
          end else begin
            div_dvd = prod;
            div_dvs = DIV_W'(ext_res);
          end
        end
      end
      ST_DIV1: begin
        if (div_stat.done) begin
          div_start = 1'b1;
          div_dvd   = DIV_W'(code_num(load_r));
          div_dvs   = div_q;
        end
      end
      default: ;
    endcase
  end

  lccc_div #(
    .W(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= iset_en ? ST_MUL : ST_DIV2;
          end
        end
        ST_MUL:  state <= ST_SRCH;
        ST_SRCH: state <= ST_CMP;
        ST_CMP: begin
          if (found) begin
            state <= (ext_res == '0) ? ST_DIV2 : ST_DIV1;
          end else if (idx == LAST_IDX) begin
            // no range fits: report error now
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            state <= ST_SRCH;
          end
        end
        ST_DIV1: begin
          if (div_stat.done) begin
            state <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_stat.done) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          load_r      <= load_ua;
          idx         <= '0;
          range_index <= LAST_IDX;  // fixed mode keeps this
        end
      end
      ST_MUL: begin
        lhs <= {20'd0, {1'b0, load_r} + 18'd1} * {18'd0, ext_res};
      end
      ST_SRCH: begin
        prod <= nom_fs(idx) * max_res;
      end
      ST_CMP: begin
        if (found) begin
          range_index <= idx;
        end else if (idx == LAST_IDX) begin
          error        <= 1'b1;
          range_index  <= '0;
          current_code <= '0;
          low_byte     <= '0;
          high_byte    <= '0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
      ST_DIV2: begin
        if (div_stat.done) begin
          error        <= 1'b0;
          current_code <= div_q[CODE_W-1:0];
          low_byte     <= div_q[7:0];
          high_byte    <= {range_index, div_q[11:8]};
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider launched while still running");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> (range_index == '0 && current_code == '0 && high_byte == '0))
    else $error("error result carries nonzero codes");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && !done))
    else $error("accepted transaction did not occupy the block");

endmodule

`default_nettype wire

[rtl/core/lccc_div.sv]
`default_nettype none

module lccc_div
  import lccc_pkg::*;
#(
  parameter int W = DIV_W
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output lccc_div_stat_t    stat,
  output logic [W-1:0]      quotient
);

  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic             active;
  logic             done_r;
  logic [W:0]       trial;
  logic             ge;

  // One quotient bit per cycle, restoring form
  assign trial = {rem, quo[W-1]} - {1'b0, dvs};
  assign ge    = !trial[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && cnt == CNT_W'(W - 1)) begin
        active <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= '0;
    end else if (active) begin
      rem <= ge ? trial[W-1:0] : {rem[W-2:0], quo[W-1]};
      quo <= {quo[W-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

  assign stat.busy = active;
  assign stat.done = done_r;
  assign quotient  = quo;

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import lccc_pkg::*;

  // Write to the unused register slot; the block must ignore it
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Nominal full-scale currents in microamps, range 0 in the low 16 bits
  localparam logic [8*16-1:0] NOMINAL_FS_UA = {
    16'd50000, 16'd30000, 16'd25000, 16'd23000,
    16'd20000, 16'd15000, 16'd10000, 16'd5000
  };

  // Leave room beyond the worst transaction for sender gaps and drains
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 120;
  localparam int PHASES         = 10;
  localparam int PHASE_LOADS    = 83;

  typedef struct packed {
    logic              error;
    logic [2:0]        range_index;
    logic [CODE_W-1:0] current_code;
    logic [7:0]        low_byte;
    logic [6:0]        high_byte;
  } code_result_t;

  typedef enum logic {ROW_LOAD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [1:0]   reg_idx;
    logic [19:0]  value;
    logic         typed;
    code_result_t want;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [LOAD_W-1:0] load_ua;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [19:0]       cfg_data;
  logic              done;
  logic              error;
  logic [2:0]        range_index;
  logic [CODE_W-1:0] current_code;
  logic [7:0]        low_byte;
  logic [6:0]        high_byte;

  led_current_code_calc dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .load_ua      (load_ua),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .error        (error),
    .range_index  (range_index),
    .current_code (current_code),
    .low_byte     (low_byte),
    .high_byte    (high_byte)
  );

  // Shadow of the configuration registers, updated when a write transaction lands
  logic        iset_en_q;
  logic [15:0] max_res_q;
  logic [19:0] ext_res_q;

  code_result_t expected_codes[$];
  stim_row_t    directed_rows[$];
  code_result_t want_res;

  int  fail_cnt;
  int  n_loads;
  int  n_writes;
  int  n_checked;
  int  n_no_range;
  int  idle_cycles;
  bit  gaps_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Full-scale current of one range after resistor scaling; a zero external
  // resistor saturates every range to the 32-bit maximum
  function automatic logic [63:0] scaled_full_scale(input int rng);
    logic [63:0] nom;
    logic [63:0] rmax;
    logic [63:0] rext;
    nom  = {48'd0, NOMINAL_FS_UA[rng*16 +: 16]};
    rmax = {48'd0, max_res_q};
    rext = {44'd0, ext_res_q};
    if (ext_res_q == 20'd0) return 64'hFFFF_FFFF;
    return (nom * rmax) / rext;
  endfunction

  function automatic code_result_t calc_current_code(input logic [LOAD_W-1:0] ld);
    code_result_t r;
    logic [63:0]  fs;
    logic [63:0]  quot;
    logic [63:0]  ld64;
    logic [2:0]   sel;
    bit           hit;
    int           i;
    r    = '0;
    fs   = 64'd0;
    sel  = 3'd0;
    hit  = 1'b0;
    ld64 = {47'd0, ld};
    if (iset_en_q) begin
      // First range whose scaled full-scale is strictly above the load wins
      for (i = 0; i < RANGE_COUNT_DEF; i++) begin
        if (!hit && ld64 < scaled_full_scale(i)) begin
          hit = 1'b1;
          sel = i[2:0];
          fs  = scaled_full_scale(i);
        end
      end
      if (!hit) begin
        r.error = 1'b1;
        return r;
      end
    end else begin
      sel = 3'(RANGE_COUNT_DEF - 1);
      fs  = {48'd0, NOMINAL_FS_UA[(RANGE_COUNT_DEF-1)*16 +: 16]};
    end
    // Fixed mode can overflow the code; keep only its low 12 bits
    quot           = (64'd4095 * ld64) / fs;
    r.range_index  = sel;
    r.current_code = quot[11:0];
    r.low_byte     = quot[7:0];
    r.high_byte    = {sel, quot[11:8]};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Drop start and hold until every expected result has come and the block is idle
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (expected_codes.size() != 0 || busy) @(negedge clk);
  endtask

  // Issue one load request; record its expected result when the transaction is taken
  task automatic send_load(input logic [LOAD_W-1:0] ld, input code_result_t exp_res);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (gaps_on && $urandom_range(0, 99) < 11) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start   = 1'b1;
    load_ua = ld;
    do @(posedge clk); while (busy);
    expected_codes.push_back(exp_res);
    n_loads++;
  endtask

  // Register write, only once the block has gone idle
  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    drain_results();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ISET_EN: iset_en_q = val[0];
      REG_MAX_RES: max_res_q = val[15:0];
      REG_EXT_RES: ext_res_q = val;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic row_load(input logic [LOAD_W-1:0] ld, input logic typed,
                          input logic e, input logic [2:0] rg, input logic [11:0] cd,
                          input logic [7:0] lo, input logic [6:0] hi);
    stim_row_t row;
    row.kind    = ROW_LOAD;
    row.reg_idx = REG_ISET_EN;
    row.value   = {3'd0, ld};
    row.typed   = typed;
    row.want    = {e, rg, cd, lo, hi};
    directed_rows.push_back(row);
  endtask

  task automatic row_cfg(input logic [1:0] idx, input logic [19:0] val);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.value   = val;
    directed_rows.push_back(row);
  endtask

  // Bias toward the edges of the active ranges, where range selection flips
  function automatic logic [LOAD_W-1:0] pick_load();
    logic [63:0] fs;
    longint      t;
    int          kind;
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      fs = iset_en_q ? scaled_full_scale($urandom_range(0, RANGE_COUNT_DEF - 1))
                     : 64'd50000;
      if (fs > 64'd131073) return LOAD_W'($urandom_range(0, 131071));
      t = longint'(fs) + longint'($urandom_range(0, 4)) - 2;
      if (t < 0) t = 0;
      if (t > 131071) t = 131071;
      return t[LOAD_W-1:0];
    end
    if (kind <= 7) return LOAD_W'($urandom_range(0, 100000));
    if (kind == 8) return LOAD_W'($urandom_range(0, 131071));
    return $urandom_range(0, 1) ? {LOAD_W{1'b1}} : {LOAD_W{1'b0}};
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("mismatch on %s, result %0d: expected %0d, got %0d",
                 name, n_checked, want, got);
    end
  endtask

  // Results last one cycle under done and cannot be held off; sample every edge
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_codes.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result: error %0d range %0d code %0d", error,
                   range_index, current_code);
      end else begin
        want_res = expected_codes.pop_front();
        cmp_field("error", want_res.error, error);
        cmp_field("range_index", want_res.range_index, range_index);
        cmp_field("current_code", want_res.current_code, current_code);
        cmp_field("low_byte", want_res.low_byte, low_byte);
        cmp_field("high_byte", want_res.high_byte, high_byte);
        if (want_res.error) n_no_range++;
        n_checked++;
      end
    end
  end

  // Watchdog: any accepted transaction or result strobe counts as progress
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || (cfg_valid && cfg_ready) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("tb failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int          ph;
    int          k;
    int          pick;
    logic [19:0] max_v;
    logic [19:0] ext_v;
    logic [LOAD_W-1:0] ld;

    rst        = 1'b1;
    start      = 1'b0;
    load_ua    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_ISET_EN;
    cfg_data   = '0;
    iset_en_q  = 1'b1;
    max_res_q  = 16'd60000;
    ext_res_q  = 20'd60000;
    fail_cnt   = 0;
    n_loads    = 0;
    n_writes   = 0;
    n_checked  = 0;
    n_no_range = 0;
    gaps_on    = 1'b1;

    // Reset defaults: scaled ranges equal the nominal ones
    row_load(17'd0,      1'b1, 1'b0, 3'd0, 12'h000, 8'h00, 7'h00);
    row_load(17'd4999,   1'b1, 1'b0, 3'd0, 12'hFFE, 8'hFE, 7'h0F);
    row_load(17'd5000,   1'b1, 1'b0, 3'd1, 12'h7FF, 8'hFF, 7'h17);
    row_load(17'd22999,  1'b0, 1'b0, 3'd0, 12'h000, 8'h00, 7'h00);
    row_load(17'd24999,  1'b0, 1'b0, 3'd0, 12'h000, 8'h00, 7'h00);
    row_load(17'd49999,  1'b1, 1'b0, 3'd7, 12'hFFE, 8'hFE, 7'h7F);
    // Load at or above the top range: no range fits, codes forced to zero
    row_load(17'd50000,  1'b1, 1'b1, 3'd0, 12'h000, 8'h00, 7'h00);
    row_load(17'd77777,  1'b1, 1'b1, 3'd0, 12'h000, 8'h00, 7'h00);
    row_load(17'd131071, 1'b1, 1'b1, 3'd0, 12'h000, 8'h00, 7'h00);
    // Fixed largest range, including code overflow past full scale
    row_cfg(REG_ISET_EN, 20'd0);
    row_load(17'd0,      1'b1, 1'b0, 3'd7, 12'h000, 8'h00, 7'h70);
    row_load(17'd50000,  1'b1, 1'b0, 3'd7, 12'hFFF, 8'hFF, 7'h7F);
    row_load(17'd100000, 1'b0, 1'b0, 3'd0, 12'h000, 8'h00, 7'h00);
    row_load(17'd131071, 1'b0, 1'b0, 3'd0, 12'h000, 8'h00, 7'h00);
    // Zero external resistor saturates every range, so range 0 always wins
    row_cfg(REG_ISET_EN, 20'd1);
    row_cfg(REG_EXT_RES, 20'd0);
    row_load(17'd131071, 1'b0, 1'b0, 3'd0, 12'h000, 8'h00, 7'h00);
    row_load(17'd0,      1'b0, 1'b0, 3'd0, 12'h000, 8'h00, 7'h00);
    // Largest scaling the register widths allow
    row_cfg(REG_EXT_RES, 20'd1);
    row_cfg(REG_MAX_RES, 20'd65535);
    row_load(17'd131071, 1'b0, 1'b0, 3'd0, 12'h000, 8'h00, 7'h00);
    row_load(17'd70000,  1'b0, 1'b0, 3'd0, 12'h000, 8'h00, 7'h00);
    // Zero maximum resistor: every scaled full-scale is zero, never chosen
    row_cfg(REG_MAX_RES, 20'd0);
    row_load(17'd0,      1'b1, 1'b1, 3'd0, 12'h000, 8'h00, 7'h00);
    // 40k variant on a 60k board: top range shrinks to 33333 uA
    row_cfg(REG_MAX_RES, 20'd40000);
    row_cfg(REG_EXT_RES, 20'd60000);
    row_load(17'd33333,  1'b1, 1'b1, 3'd0, 12'h000, 8'h00, 7'h00);
    row_load(17'd33332,  1'b0, 1'b0, 3'd0, 12'h000, 8'h00, 7'h00);
    // Unused register slot; settings must stay as they were
    row_cfg(REG_SPARE, 20'hFFFFF);
    row_load(17'd33332,  1'b0, 1'b0, 3'd0, 12'h000, 8'h00, 7'h00);
    // Largest external resistor: tiny ranges
    row_cfg(REG_EXT_RES, 20'hFFFFF);
    row_cfg(REG_MAX_RES, 20'd60000);
    row_load(17'd300,    1'b0, 1'b0, 3'd0, 12'h000, 8'h00, 7'h00);

    // Hold reset, then release it on a falling edge
    repeat (8) @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        ld = directed_rows[i].value[LOAD_W-1:0];
        send_load(ld, directed_rows[i].typed ? directed_rows[i].want
                                             : calc_current_code(ld));
      end
    end

    // Random phases, each under a fresh register setting
    for (ph = 0; ph < PHASES; ph++) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0:       max_v = 20'd60000;
        1:       max_v = 20'd40000;
        2:       max_v = 20'd1;
        3:       max_v = 20'd65535;
        default: max_v = 20'($urandom_range(1, 65535));
      endcase
      pick = $urandom_range(0, 7);
      case (pick)
        0:       ext_v = 20'd60000;
        1:       ext_v = 20'd40000;
        2:       ext_v = 20'd0;
        3:       ext_v = 20'd1;
        4:       ext_v = 20'hFFFFF;
        5:       ext_v = 20'($urandom_range(1, 1048575));
        default: ext_v = 20'($urandom_range(1, 2 * int'(max_v) + 1));
      endcase
      // First phase runs the reset resistor values so most loads land in range
      if (ph == 0) begin
        max_v = 20'd60000;
        ext_v = 20'd60000;
      end
      write_reg(REG_ISET_EN, 20'($urandom_range(0, 3) != 0));
      write_reg(REG_MAX_RES, max_v);
      write_reg(REG_EXT_RES, ext_v);

      // One phase runs back to back with no sender gaps
      gaps_on = (ph != 2);
      for (k = 0; k < PHASE_LOADS; k++) begin
        if (ph == 5 && k == PHASE_LOADS / 2) drain_results();
        ld = pick_load();
        send_load(ld, calc_current_code(ld));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d load requests over %0d register writes; %0d results checked,",
             n_loads, n_writes, n_checked);
    $display("%0d of them with no fitting range, %0d field mismatches", n_no_range, fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
